/* design/dhg_pkg.sv */
// ----------------------------------------------------------------------------
// dhg_pkg: shared types and constants of the hit grouper
// Hit and photon payload structs, configuration set and register indexes.
// ----------------------------------------------------------------------------
package dhg_pkg;

  localparam int DEF_BUFFER_DEPTH = 64;
  localparam int DEF_MAX_HITS     = 8;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OVERLAP = 2'd2;

  typedef struct packed {
    logic [11:0]        hit_region;
    logic [47:0]        hit_time;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic signed [15:0] hit_z;
    logic [23:0]        hit_energy;
    logic [23:0]        hit_missing_energy;
    logic [7:0]         hit_missing_count;
    logic               batch_last;
  } hit_t;

  typedef struct packed {
    logic [3:0]         photon_hits;
    logic [11:0]        photon_region;
    logic [47:0]        photon_time;
    logic signed [15:0] photon_x;
    logic signed [15:0] photon_y;
    logic signed [15:0] photon_z;
    logic [27:0]        photon_energy;
    logic [27:0]        photon_missing_energy;
    logic [11:0]        photon_missing_count;
    logic               batch_overflow;
    logic               photon_last;
  } photon_t;

  typedef struct packed {
    logic [31:0] radius_squared;
    logic [31:0] time_window;
    logic [31:0] overlap_time;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic overflow;
  } go_t;

endpackage

/* design/detector_hit_grouper.sv */
// ----------------------------------------------------------------------------
// detector_hit_grouper: time window spatial clustering of detector hits
// Collects a batch of hits and groups them into photons by region, distance
// and time, one result per kept photon.
// ----------------------------------------------------------------------------
// usage: hits arrive on hit_valid/hit_stall/hit, one transfer per hit. hits
// are stored until one with batch_last set; hit_stall then stays high while
// the batch is scanned. photons leave on photon_valid/photon_stall/photon in
// seed order, the final one carrying photon_last; a batch with no kept photon
// gives one end marker with photon_hits zero.
// intake takes one hit per cycle while hit_stall is low. the scan works one
// seed at a time, skipping hits already taken and comparing each candidate
// hit in order (one store read, squaring, decision), bounded by the time stop.
// a four entry photon queue sits before the output; a stalled receiver
// stalls the scan only once that queue is full.
// configuration writes (write_en, write_index, write_data) are to go in while idle;
// the block itself does not enforce this. synchronous reset clears the batch,
// the queue and the registers.
module detector_hit_grouper #(
  parameter int BUFFER_DEPTH = dhg_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_HITS = dhg_pkg::DEF_MAX_HITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_en,
  input  logic [dhg_pkg::REG_IDX_W-1:0]   write_index,
  input  logic [31:0]                     write_data,
  input  logic                            hit_valid,
  output logic                            hit_stall,
  input  dhg_pkg::hit_t                   hit,
  output logic                            photon_valid,
  input  logic                            photon_stall,
  output dhg_pkg::photon_t                photon
);
  import dhg_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  cfg_t          cfg;
  go_t           go;
  logic [CW-1:0] count;
  logic          done;
  logic [AW-1:0] raddr;
  hit_t          rdata;
  logic          q_push;
  photon_t       q_data;
  logic          q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_en) begin
      unique case (write_index)
        REG_RADIUS:  cfg.radius_squared <= write_data;
        REG_WINDOW:  cfg.time_window    <= write_data;
        REG_OVERLAP: cfg.overlap_time   <= write_data;
        default: begin
        end
      endcase
    end
  end

  dhg_front #(.BUFFER_DEPTH(BUFFER_DEPTH), .AW(AW), .CW(CW)) u_front (
    .clk, .rst, .hit_valid, .hit_stall, .hit,
    .go, .count, .done, .raddr, .rdata
  );

  dhg_scan #(.BUFFER_DEPTH(BUFFER_DEPTH), .MAX_HITS(MAX_HITS), .AW(AW), .CW(CW)) u_scan (
    .clk, .rst, .cfg, .go, .count, .done, .raddr, .rdata,
    .q_push, .q_data, .q_full
  );

  dhg_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst, .push(q_push), .din(q_data), .full(q_full),
    .photon_valid, .photon_stall, .photon
  );

endmodule

/* design/dhg_front.sv */
// ----------------------------------------------------------------------------
// dhg_front: hit intake and batch store
// Takes hits into the store until the batch end, then hands the batch over.
// ----------------------------------------------------------------------------
module dhg_front #(
  parameter int BUFFER_DEPTH = dhg_pkg::DEF_BUFFER_DEPTH,
  parameter int AW = $clog2(BUFFER_DEPTH),
  parameter int CW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hit_valid,
  output logic          hit_stall,
  input  dhg_pkg::hit_t hit,
  output dhg_pkg::go_t  go,
  output logic [CW-1:0] count,
  input  logic          done,
  input  logic [AW-1:0] raddr,
  output dhg_pkg::hit_t rdata
);
  import dhg_pkg::*;

  hit_t mem [BUFFER_DEPTH];
  logic busy;
  logic overflow;
  logic start;
  logic take;
  logic room;

  assign take = hit_valid && !busy;
  assign room = 32'(count) < BUFFER_DEPTH;
  assign hit_stall = busy;
  assign go = '{start: start, overflow: overflow};

  always_ff @(posedge clk) begin
    if (take && room) begin
      mem[count[AW-1:0]] <= hit;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      overflow <= 1'b0;
      count    <= '0;
      start    <= 1'b0;
    end else begin
      start <= 1'b0;
      if (take) begin
        if (room) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
        if (hit.batch_last) begin
          busy  <= 1'b1;
          start <= 1'b1;
        end
      end
      if (done) begin
        busy     <= 1'b0;
        overflow <= 1'b0;
        count    <= '0;
      end
    end
  end

endmodule

/* design/dhg_scan.sv */
// ----------------------------------------------------------------------------
// dhg_scan: seed and candidate scan over the stored batch
// Builds photons one seed at a time and queues them, marking the last one.
// ----------------------------------------------------------------------------
module dhg_scan #(
  parameter int BUFFER_DEPTH = dhg_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_HITS = dhg_pkg::DEF_MAX_HITS,
  parameter int AW = $clog2(BUFFER_DEPTH),
  parameter int CW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  dhg_pkg::cfg_t    cfg,
  input  dhg_pkg::go_t     go,
  input  logic [CW-1:0]    count,
  output logic             done,
  output logic [AW-1:0]    raddr,
  input  dhg_pkg::hit_t    rdata,
  output logic             q_push,
  output dhg_pkg::photon_t q_data,
  input  logic             q_full
);
  import dhg_pkg::*;

  localparam int SW  = $clog2(MAX_HITS + 1);
  localparam int ESW = 24 + SW;
  localparam int MSW = 8 + SW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEEK  = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_CAND  = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0]  state;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [BUFFER_DEPTH-1:0] taken;
  hit_t        seed;
  hit_t        cand;
  hit_t        first;
  logic [CW-1:0] members;
  logic [ESW-1:0] e_sum;
  logic [ESW-1:0] me_sum;
  logic [MSW-1:0] mc_sum;
  logic        have_pend;
  photon_t     pend;
  photon_t     cur;
  photon_t     marker;
  logic [31:0] sq_x, sq_y, sq_z;
  logic        same_region, past_stop, in_window;

  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] px, py, pz;
  logic signed [49:0] dt;
  logic [49:0]        adt;
  logic [32:0]        stop;
  logic [33:0]        sq_sum;
  logic               near;

  assign dx = $signed({rdata.hit_x[15], rdata.hit_x}) - $signed({seed.hit_x[15], seed.hit_x});
  assign dy = $signed({rdata.hit_y[15], rdata.hit_y}) - $signed({seed.hit_y[15], seed.hit_y});
  assign dz = $signed({rdata.hit_z[15], rdata.hit_z}) - $signed({seed.hit_z[15], seed.hit_z});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;
  assign dt = $signed({2'b00, rdata.hit_time}) - $signed({2'b00, seed.hit_time});
  assign adt = dt[49] ? 50'(-dt) : 50'(dt);
  assign stop = {1'b0, cfg.overlap_time} + {1'b0, cfg.time_window};
  assign sq_sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
  assign near = sq_sum < {2'b00, cfg.radius_squared};

  always_comb begin
    cur.photon_hits = (32'(members) > 15) ? 4'd15 : 4'(members);
    cur.photon_region = first.hit_region;
    cur.photon_time = first.hit_time;
    cur.photon_x = first.hit_x;
    cur.photon_y = first.hit_y;
    cur.photon_z = first.hit_z;
    cur.photon_energy = (32'(e_sum) > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : 28'(e_sum);
    cur.photon_missing_energy =
      (32'(me_sum) > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : 28'(me_sum);
    cur.photon_missing_count = (32'(mc_sum) > 32'h0FFF) ? 12'hFFF : 12'(mc_sum);
    cur.batch_overflow = go.overflow;
    cur.photon_last = 1'b0;
    marker = '0;
    marker.batch_overflow = go.overflow;
    marker.photon_last = 1'b1;
  end

  always_comb begin
    raddr  = (state == S_SEEK) ? i[AW-1:0] : j[AW-1:0];
    q_push = 1'b0;
    q_data = pend;
    done   = 1'b0;
    unique case (state)
      S_EMIT: begin
        q_push = (32'(members) <= MAX_HITS) && have_pend && !q_full;
      end
      S_FLUSH: begin
        q_push = !q_full;
        done   = !q_full;
        if (have_pend) begin
          q_data.photon_last = 1'b1;
        end else begin
          q_data = marker;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      taken     <= '0;
      have_pend <= 1'b0;
      i         <= '0;
      j         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go.start) begin
            i         <= '0;
            have_pend <= 1'b0;
            state     <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (i == count) begin
            state <= S_FLUSH;
          end else if (taken[i[AW-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          taken[i[AW-1:0]] <= 1'b1;
          j     <= i + 1'b1;
          state <= S_CAND;
        end
        S_CAND: begin
          if (j == count) begin
            state <= S_EMIT;
          end else if (taken[j[AW-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (same_region && past_stop) begin
            state <= S_EMIT;
          end else begin
            if (same_region && near && in_window) begin
              taken[j[AW-1:0]] <= 1'b1;
            end
            j     <= j + 1'b1;
            state <= S_CAND;
          end
        end
        S_EMIT: begin
          if (32'(members) > MAX_HITS) begin
            i     <= i + 1'b1;
            state <= S_SEEK;
          end else if (!(have_pend && q_full)) begin
            have_pend <= 1'b1;
            i         <= i + 1'b1;
            state     <= S_SEEK;
          end
        end
        S_FLUSH: begin
          if (!q_full) begin
            taken <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEED) begin
      seed    <= rdata;
      first   <= rdata;
      members <= CW'(1);
      e_sum   <= ESW'(rdata.hit_energy);
      me_sum  <= ESW'(rdata.hit_missing_energy);
      mc_sum  <= MSW'(rdata.hit_missing_count);
    end
    if (state == S_SQ) begin
      cand        <= rdata;
      sq_x        <= px[31:0];
      sq_y        <= py[31:0];
      sq_z        <= pz[31:0];
      same_region <= rdata.hit_region == seed.hit_region;
      past_stop   <= dt > $signed({17'd0, stop});
      in_window   <= adt <= {18'd0, cfg.time_window};
    end
    if (state == S_DEC && same_region && !past_stop && near && in_window) begin
      members <= members + 1'b1;
      if (32'(members) < MAX_HITS) begin
        if (cand.hit_time < first.hit_time) begin
          first <= cand;
        end
        e_sum  <= e_sum + ESW'(cand.hit_energy);
        me_sum <= me_sum + ESW'(cand.hit_missing_energy);
        mc_sum <= mc_sum + MSW'(cand.hit_missing_count);
      end
    end
    if (state == S_EMIT && 32'(members) <= MAX_HITS && !(have_pend && q_full)) begin
      pend <= cur;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");
  a_members_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC || state == S_EMIT) |-> members <= count)
    else $error("member count beyond batch");
  a_cand_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DEC |-> (j < count && j > i)) else $error("candidate index out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_IDLE) else $error("scan not idle after batch end");
`endif

endmodule

/* design/dhg_fifo.sv */
// ----------------------------------------------------------------------------
// dhg_fifo: short photon queue
// Decouples the scan engine from the output receiver.
// ----------------------------------------------------------------------------
module dhg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dhg_pkg::photon_t din,
  output logic             full,
  output logic             photon_valid,
  input  logic             photon_stall,
  output dhg_pkg::photon_t photon
);
  import dhg_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  photon_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;
  logic pop;

  assign full = 32'(fill) == DEPTH;
  assign photon_valid = fill != '0;
  assign pop = photon_valid && !photon_stall;
  assign photon = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (32'(wptr) == DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (32'(rptr) == DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      fill <= fill + NW'(push) - NW'(pop);
    end
  end

endmodule
